[rtl/gfd_pkg.sv]
// gfd_pkg: word types and register index codes for the gradient filter
// pixel decoder. No dependencies.

package gfd_pkg;

  localparam int RAW_W   = 32;
  localparam int COLOR_W = 32;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 16;
  localparam int COMP_W  = 8;
  localparam int CFG_W   = 32;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pixel;
    logic             rect_start;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic               row_end;
  } result_t;

  typedef enum logic [2:0] {
    CFG_ROW_WIDTH    = 3'd0,
    CFG_COMPACT_MODE = 3'd1,
    CFG_RED_MAX      = 3'd2,
    CFG_GREEN_MAX    = 3'd3,
    CFG_BLUE_MAX     = 3'd4,
    CFG_RED_SHIFT    = 3'd5,
    CFG_GREEN_SHIFT  = 3'd6,
    CFG_BLUE_SHIFT   = 3'd7
  } cfg_index_t;

endpackage

[rtl/gfd_ram.sv]
// gfd_ram: generic simple dual-port ram, one write and one read port,
// registered read data. No dependencies.

module gfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/gradient_filter_pixel_decoder.sv]
// gradient_filter_pixel_decoder: top level, undoes the gradient filter on a
// pixel stream. Depends on gfd_pkg and gfd_ram.
//
// One pixel word is taken per clock cycle while pixel_stall is low; its result
// word passes the stage 1 and output registers. The row above lives in a line
// store ram of MAX_WIDTH entries: the pixel's column is read in the accept
// cycle, and in the next cycle above, left and above-left feed one add, clamp
// and add per component before the result lands in the output register and
// the new components are written back. A write to the column being read in
// the same cycle is forwarded. The line store needs no clearing pass; its data
// is only used on rows after the first. The user must write configuration via
// the always-ready cfg channel only while idle; the block does not enforce it.

module gradient_filter_pixel_decoder
  import gfd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  pixel_t             pixel,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_index_t         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = 3 * COMP_W;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic             last;
  } stage_t;

  // configuration registers
  logic [11:0] row_width;
  logic        compact_mode;
  logic [7:0]  red_max, green_max, blue_max;
  logic [4:0]  red_shift, green_shift, blue_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= 12'd1;
      compact_mode <= 1'b0;
      red_max      <= 8'hff;
      green_max    <= 8'hff;
      blue_max     <= 8'hff;
      red_shift    <= 5'd16;
      green_shift  <= 5'd8;
      blue_shift   <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_WIDTH:    row_width    <= cfg_data[11:0];
        CFG_COMPACT_MODE: compact_mode <= cfg_data[0];
        CFG_RED_MAX:      red_max      <= cfg_data[7:0];
        CFG_GREEN_MAX:    green_max    <= cfg_data[7:0];
        CFG_BLUE_MAX:     blue_max     <= cfg_data[7:0];
        CFG_RED_SHIFT:    red_shift    <= cfg_data[4:0];
        CFG_GREEN_SHIFT:  green_shift  <= cfg_data[4:0];
        CFG_BLUE_SHIFT:   blue_shift   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic    s1_valid, s1_adv, accept;
  stage_t  s1, s1_next;
  logic    s1_fwd;
  logic [LW-1:0] s1_fwd_data;

  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;

  // stage 0: position tracking and line store read
  logic [CW-1:0]    column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [11:0]      eff_width;
  logic [CW-1:0]    col0;
  logic [ROW_W-1:0] row0;
  logic             last0;

  always_comb begin
    if (row_width == 12'd0) begin
      eff_width = 12'd1;
    end else if (32'(row_width) > MAX_WIDTH) begin
      eff_width = 12'(MAX_WIDTH);
    end else begin
      eff_width = row_width;
    end
    col0  = pixel.rect_start ? '0 : column_count;
    row0  = pixel.rect_start ? '0 : row_count;
    last0 = (32'(col0) + 32'd1) >= 32'(eff_width);
    if (last0) begin
      column_count_next = '0;
      row_count_next    = (row0 == '1) ? row0 : row0 + 1'b1;
    end else begin
      column_count_next = col0 + 1'b1;
      row_count_next    = row0;
    end
    s1_next.raw  = pixel.raw_pixel;
    s1_next.col  = col0;
    s1_next.row  = row0;
    s1_next.last = last0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // stage 1: reconstruction
  logic [LW-1:0]    ram_q, above, left, upleft, cur;
  logic [RAW_W-1:0] raw1;
  logic [COLOR_W-1:0] color1;
  logic [7:0]       maxv [3];
  logic [4:0]       shv [3];
  logic [7:0]       resid [3];
  logic [7:0]       pred [3];
  logic [7:0]       comp [3];
  logic signed [9:0] d [3];
  logic [LW-1:0]    left_components, upleft_components;

  assign maxv[0] = red_max;
  assign maxv[1] = green_max;
  assign maxv[2] = blue_max;
  assign shv[0]  = red_shift;
  assign shv[1]  = green_shift;
  assign shv[2]  = blue_shift;

  always_comb begin
    raw1 = compact_mode ? {8'h00, s1.raw[7:0], s1.raw[15:8], s1.raw[23:16]} : s1.raw;
    above  = (s1.row == '0) ? '0 : (s1_fwd ? s1_fwd_data : ram_q);
    left   = (s1.col == '0) ? '0 : left_components;
    upleft = (s1.row == '0 || s1.col == '0) ? '0 : upleft_components;
    cur    = '0;
    color1 = '0;
    for (int k = 0; k < 3; k++) begin
      resid[k] = 8'(raw1 >> shv[k]) & maxv[k];
      d[k] = $signed({2'b00, above[LW-1-8*k -: 8]}) + $signed({2'b00, left[LW-1-8*k -: 8]})
           - $signed({2'b00, upleft[LW-1-8*k -: 8]});
      if (d[k] < 0) begin
        pred[k] = '0;
      end else if (d[k] > $signed({2'b00, maxv[k]})) begin
        pred[k] = maxv[k];
      end else begin
        pred[k] = d[k][7:0];
      end
      comp[k] = (pred[k] + resid[k]) & maxv[k];
      cur[LW-1-8*k -: 8] = comp[k];
      color1 = color1 | (COLOR_W'(comp[k]) << shv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1          <= s1_next;
      s1_fwd      <= s1_adv && (s1.col == col0);
      s1_fwd_data <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_components   <= '0;
      upleft_components <= '0;
    end else if (s1_adv) begin
      left_components   <= cur;
      upleft_components <= above;
    end
  end

  gfd_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1.col),
    .wr_data (cur),
    .rd_en   (accept),
    .rd_addr (col0),
    .rd_data (ram_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.color   <= color1;
      result.column  <= COL_W'(s1.col);
      result.row     <= s1.row;
      result.row_end <= s1.last;
    end
  end

  // checks
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && pixel.rect_start |=> s1.col == '0 && s1.row == '0)
    else $error("rectangle start did not restart position");

  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("advanced word missing at output");

  a_fwd_col: assert property (@(posedge clk) disable iff (rst)
    accept && s1_adv && s1.col == col0 |=> s1_fwd)
    else $error("same-column read not forwarded");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("stalled stage word changed");

endmodule

[verif/tb_gradient_filter_pixel_decoder.sv]
// tb_gradient_filter_pixel_decoder: self-checking testbench for the gradient
// filter pixel decoder, with a line-store predictor, bursty pixel traffic and
// random result stalls. Depends on gfd_pkg and gradient_filter_pixel_decoder.

module tb_gradient_filter_pixel_decoder;
  import gfd_pkg::*;

  localparam int MAX_WIDTH      = 2048;
  localparam int HOLD_CYCLES    = 80;
  localparam int IDLE_SETTLE    = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pixel_valid = 1'b0;
  logic             pixel_stall;
  pixel_t           pixel = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_index_t       cfg_index = CFG_ROW_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state and register copies
  logic [23:0] line_mem [MAX_WIDTH];
  bit          line_written [MAX_WIDTH];
  logic [23:0] left_cmp = '0;
  logic [23:0] upleft_cmp = '0;
  int          col_cnt = 0;
  int          row_cnt = 0;
  logic [11:0] width_reg = 12'd1;
  logic        compact_reg = 1'b0;
  logic [7:0]  comp_max [3] = '{8'hFF, 8'hFF, 8'hFF};
  logic [4:0]  comp_shift [3] = '{5'd16, 5'd8, 5'd0};

  result_t     expected_results [$];
  result_t     exp_word;
  int          error_count = 0;
  int          stuck_cycles = 0;
  int          burst_left = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  rx_mode_t    stall_mode = RX_FREE;

  gradient_filter_pixel_decoder #(.MAX_WIDTH(MAX_WIDTH)) uut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t decode_pixel(pixel_t word);
    logic [31:0] raw, color, raw_sh;
    logic [23:0] above, left_px, upleft_px, cur;
    logic [7:0]  resid, pred, a, l, u;
    logic [8:0]  sum;
    int          width, col, row, diff, k;
    result_t     r;
    if (word.rect_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    raw = word.raw_pixel;
    if (compact_reg) raw = {8'h00, raw[7:0], raw[15:8], raw[23:16]};
    width = int'(width_reg);
    if (width == 0) width = 1;
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    col = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
    row = row_cnt;
    above = (row == 0) ? 24'h0 : line_mem[col];
    left_px = (col == 0) ? 24'h0 : left_cmp;
    upleft_px = (row == 0 || col == 0) ? 24'h0 : upleft_cmp;
    color = '0;
    cur = '0;
    for (k = 0; k < 3; k++) begin
      raw_sh = raw >> comp_shift[k];
      resid = raw_sh[7:0] & comp_max[k];
      a = above[16-8*k +: 8];
      l = left_px[16-8*k +: 8];
      u = upleft_px[16-8*k +: 8];
      diff = int'(a) + int'(l) - int'(u);
      if (diff < 0) pred = 8'h00;
      else if (diff > int'(comp_max[k])) pred = comp_max[k];
      else pred = diff[7:0];
      sum = pred + resid;
      cur[16-8*k +: 8] = sum[7:0] & comp_max[k];
      color |= {24'h0, cur[16-8*k +: 8]} << comp_shift[k];
    end
    line_mem[col] = cur;
    line_written[col] = 1'b1;
    left_cmp = cur;
    upleft_cmp = above;
    r.color = color;
    r.column = col[10:0];
    r.row = row[15:0];
    r.row_end = (col + 1 >= width);
    if (r.row_end) begin
      col_cnt = 0;
      if (row_cnt < 65535) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
    return r;
  endfunction

  function automatic void apply_register(cfg_index_t idx, logic [31:0] data);
    case (idx)
      CFG_ROW_WIDTH:    width_reg = data[11:0];
      CFG_COMPACT_MODE: compact_reg = data[0];
      CFG_RED_MAX:      comp_max[0] = data[7:0];
      CFG_GREEN_MAX:    comp_max[1] = data[7:0];
      CFG_BLUE_MAX:     comp_max[2] = data[7:0];
      CFG_RED_SHIFT:    comp_shift[0] = data[4:0];
      CFG_GREEN_SHIFT:  comp_shift[1] = data[4:0];
      CFG_BLUE_SHIFT:   comp_shift[2] = data[4:0];
      default:          ;
    endcase
  endfunction

  function automatic logic [31:0] with_noise(logic [31:0] v, int bits, bit noisy);
    logic [31:0] junk;
    junk = $urandom;
    return noisy ? (((junk >> bits) << bits) | v) : v;
  endfunction

  function automatic logic [31:0] random_raw();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom & 32'h0303_0303;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3, 4, 5, 6: return 8'((1 << $urandom_range(1, 8)) - 1);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [4:0] pick_shift(logic [4:0] usual);
    return ($urandom_range(0, 1) == 0) ? usual : 5'($urandom_range(0, 31));
  endfunction

  task automatic report_mismatch(string field, logic [31:0] e, logic [31:0] g);
    error_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, e, g);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [31:0] raw, input logic start);
    pixel_t word;
    if (burst_left == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    word.raw_pixel = raw;
    // never let a pixel read a line store entry that was never written
    word.rect_start = start || (row_cnt != 0 && !line_written[col_cnt]);
    pixel <= word;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    expected_results.push_back(decode_pixel(word));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [11:0] w, input logic compact,
                           input logic [7:0] rmax, input logic [7:0] gmax,
                           input logic [7:0] bmax, input logic [4:0] rsh,
                           input logic [4:0] gsh, input logic [4:0] bsh,
                           input bit noisy);
    wait_idle();
    write_register(CFG_ROW_WIDTH, with_noise(32'(w), 12, noisy));
    write_register(CFG_COMPACT_MODE, with_noise(32'(compact), 1, noisy));
    write_register(CFG_RED_MAX, with_noise(32'(rmax), 8, noisy));
    write_register(CFG_GREEN_MAX, with_noise(32'(gmax), 8, noisy));
    write_register(CFG_BLUE_MAX, with_noise(32'(bmax), 8, noisy));
    write_register(CFG_RED_SHIFT, with_noise(32'(rsh), 5, noisy));
    write_register(CFG_GREEN_SHIFT, with_noise(32'(gsh), 5, noisy));
    write_register(CFG_BLUE_SHIFT, with_noise(32'(bsh), 5, noisy));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
  endtask

  task automatic test_borders();
    send_pixel(32'hFFFF_FFFF, 1'b0);
    configure(12'd3, 1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd16, 5'd8, 5'd0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0001_0101, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel($urandom, 1'b0);
  endtask

  task automatic test_compact_bytes();
    configure(12'd2, 1'b1, 8'hFF, 8'hFF, 8'hFF, 5'd16, 5'd8, 5'd0, 1'b0);
    send_pixel(32'hAA11_2233, 1'b1);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel($urandom, 1'b0);
  endtask

  task automatic test_masks_and_shifts();
    configure(12'd2, 1'b0, 8'h00, 8'h5A, 8'h01, 5'd31, 5'd25, 5'd0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h8000_0001, 1'b0);
    send_pixel($urandom, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    configure(12'd2, 1'b0, 8'hFF, 8'h03, 8'hFF, 5'd31, 5'd0, 5'd24, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);
  endtask

  task automatic test_width_limits();
    int i;
    configure(12'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd16, 5'd8, 5'd0, 1'b0);
    for (i = 0; i < 3; i++) send_pixel(random_raw(), i == 0);
    configure(12'd4095, 1'b0, 8'h7F, 8'hFF, 8'h0F, 5'd16, 5'd8, 5'd0, 1'b0);
    for (i = 0; i < 60; i++) send_pixel(random_raw(), i == 0);
  endtask

  task automatic test_width_change_mid_row();
    int i;
    configure(12'd6, 1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd16, 5'd8, 5'd0, 1'b0);
    for (i = 0; i < 4; i++) send_pixel(random_raw(), i == 0);
    wait_idle();
    // column 4 is already past the new width, so the next pixel ends the row
    write_register(CFG_ROW_WIDTH, 32'd2);
    cfg_valid <= 1'b0;
    for (i = 0; i < 4; i++) send_pixel(random_raw(), 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    configure(12'd5, 1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd16, 5'd8, 5'd0, 1'b0);
    burst_left = 100;
    hold_requests++;
    for (i = 0; i < 40; i++) send_pixel(random_raw(), i == 0);
    wait_idle();
    burst_left = 100;
    hold_requests++;
    for (i = 0; i < 25; i++) send_pixel(random_raw(), 1'b0);
  endtask

  task automatic test_random_rectangles();
    int          phase, sent, rows, w, n, i;
    logic [11:0] width_val;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0:       width_val = 12'd0;
        1:       width_val = 12'd1;
        2:       width_val = 12'($urandom_range(17, 64));
        default: width_val = 12'($urandom_range(2, 16));
      endcase
      configure(width_val, 1'($urandom_range(0, 1)), pick_mask(), pick_mask(),
                pick_mask(), pick_shift(5'd16), pick_shift(5'd8), pick_shift(5'd0), 1'b1);
      w = (width_val == 0) ? 1 : int'(width_val);
      sent = 0;
      while (sent < 205) begin
        if ($urandom_range(0, 6) != 0) begin
          rows = $urandom_range(1, (w > 40) ? 2 : 6);
          n = rows * w + (($urandom_range(0, 3) == 0) ? $urandom_range(1, w) : 0);
          for (i = 0; i < n; i++) send_pixel(random_raw(), i == 0);
        end else begin
          // broken rectangles: starts dropped in at random
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) send_pixel(random_raw(), $urandom_range(0, 3) == 0);
        end
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_borders();
    test_compact_bytes();
    test_masks_and_shifts();
    test_width_limits();
    test_width_change_mid_row();
    test_backpressure();
    test_random_rectangles();
    pixel_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver stall pattern, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      case (stall_mode)
        RX_FREE:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: result_stall <= ($urandom_range(0, 1) == 0);
        default:  result_stall <= (mode_left % 4 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected, expected none, got %h", $time, result);
      end else begin
        exp_word = expected_results.pop_front();
        if (result.color !== exp_word.color)
          report_mismatch("color", exp_word.color, result.color);
        if (result.column !== exp_word.column)
          report_mismatch("column", 32'(exp_word.column), 32'(result.column));
        if (result.row !== exp_word.row)
          report_mismatch("row", 32'(exp_word.row), 32'(result.row));
        if (result.row_end !== exp_word.row_end)
          report_mismatch("row_end", 32'(exp_word.row_end), 32'(result.row_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
